### hw/rtl/efc_pkg.sv
package efc_pkg;

    localparam int RTC_W      = 24;
    localparam int USEC_W     = 10;
    localparam int COUNT_W    = 32;
    localparam int FREQ_W     = 32;
    localparam int SCALE_W    = 20;
    localparam int NUM_W      = COUNT_W + SCALE_W;
    localparam int TIME_BITS_DEF = 24;

    localparam logic [SCALE_W-1:0] USEC_PER_SEC   = SCALE_W'(1000000);
    localparam logic [USEC_W-1:0]  USEC_RESET     = USEC_W'(31);

    typedef enum logic [1:0] {
        CMD_EDGE   = 2'd0,
        CMD_UPDATE = 2'd1,
        CMD_START  = 2'd2,
        CMD_STOP   = 2'd3
    } efc_cmd_t;

    // what the back end does to the frequency register
    typedef enum logic [1:0] {
        KIND_KEEP,
        KIND_ZERO,
        KIND_DIV
    } efc_kind_t;

    typedef struct packed {
        efc_kind_t            kind;
        logic                 running;
        logic [COUNT_W-1:0]   count;
    } efc_op_t;

    localparam int OP_W = $bits(efc_op_t);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } efc_state_t;

endpackage

### hw/rtl/efc_front.sv
module efc_front #(
    parameter int TIME_BITS = efc_pkg::TIME_BITS_DEF,
    parameter int ENTRY_W   = TIME_BITS + efc_pkg::OP_W
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [1:0]                command,
    input  logic [efc_pkg::RTC_W-1:0] rtc_time,
    output logic                      push,
    output logic [ENTRY_W-1:0]        push_data,
    input  logic                      q_full
);
    import efc_pkg::*;

    localparam int NOW_W = (TIME_BITS > RTC_W) ? TIME_BITS : RTC_W;

    logic                 run_reg, run_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic [TIME_BITS-1:0] last_reg, last_next;
    logic [NOW_W-1:0]     now_wide;
    logic [TIME_BITS-1:0] now_t;
    logic [TIME_BITS-1:0] elapsed;
    logic                 accept;
    efc_op_t              op;

    assign in_stall  = q_full;
    assign accept    = in_valid && !q_full;
    assign push      = accept;
    assign now_wide  = NOW_W'(rtc_time);
    assign now_t     = now_wide[TIME_BITS-1:0];
    assign elapsed   = now_t - last_reg;   // wraps modulo the timestamp width
    assign push_data = {elapsed, op};

    always_comb
    begin
        run_next   = run_reg;
        count_next = count_reg;
        last_next  = last_reg;
        op.kind    = KIND_KEEP;
        op.count   = count_reg;
        case (efc_cmd_t'(command))
            CMD_EDGE:
            begin
                if (run_reg)
                begin
                    count_next = count_reg + COUNT_W'(1);
                end
            end
            CMD_UPDATE:
            begin
                if (run_reg)
                begin
                    op.kind    = KIND_DIV;
                    count_next = '0;
                    last_next  = now_t;
                end
                else
                begin
                    op.kind = KIND_ZERO;
                end
            end
            CMD_START:
            begin
                count_next = '0;
                last_next  = now_t;
                run_next   = 1'b1;
            end
            CMD_STOP:
            begin
                run_next = 1'b0;
                op.kind  = KIND_ZERO;
            end
            default:
            begin
                op.kind = KIND_KEEP;
            end
        endcase
        op.running = run_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg   <= 1'b0;
            count_reg <= '0;
            last_reg  <= '0;
        end
        else if (accept)
        begin
            run_reg   <= run_next;
            count_reg <= count_next;
            last_reg  <= last_next;
        end
    end

    a_start_runs: assert property (@(posedge clk) disable iff (!rst_n)
        accept && command == CMD_START |=> run_reg && count_reg == '0)
        else $error("start did not set running");

    a_stop_halts: assert property (@(posedge clk) disable iff (!rst_n)
        accept && command == CMD_STOP |=> !run_reg)
        else $error("stop did not clear running");

    a_idle_edge: assert property (@(posedge clk) disable iff (!rst_n)
        accept && command == CMD_EDGE && !run_reg |=> $stable(count_reg))
        else $error("edge counted while stopped");

endmodule

### hw/rtl/efc_queue.sv
module efc_queue #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             q_valid,
    output logic [WIDTH-1:0] pop_data
);
    import efc_pkg::*;

    logic [WIDTH-1:0] mem [2];
    logic             wr_ptr_reg, rd_ptr_reg;
    logic [1:0]       fill_reg, fill_next;

    assign full     = fill_reg == 2'd2;
    assign q_valid  = fill_reg != 2'd0;
    assign pop_data = mem[rd_ptr_reg];

    always_comb
    begin
        fill_next = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            fill_reg <= fill_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_valid)
        else $error("pop from empty queue");

    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg != 2'd3)
        else $error("queue fill out of range");

endmodule

### hw/rtl/efc_back.sv
module efc_back #(
    parameter int TIME_BITS = efc_pkg::TIME_BITS_DEF,
    parameter int ENTRY_W   = TIME_BITS + efc_pkg::OP_W
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       q_valid,
    input  logic [ENTRY_W-1:0]         pop_data,
    output logic                       pop,
    input  logic [efc_pkg::USEC_W-1:0] usec_per_tick,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [efc_pkg::FREQ_W-1:0] freq_hz,
    output logic                       running,
    output logic                       divide_fault
);
    import efc_pkg::*;

    localparam int DW     = TIME_BITS + USEC_W;
    localparam int ITER_W = $clog2(NUM_W);

    efc_state_t           state_reg, state_next;
    efc_op_t              head;
    logic [TIME_BITS-1:0] head_ticks;
    logic                 out_free;

    logic                 out_valid_reg, out_valid_next;
    logic [FREQ_W-1:0]    freq_reg, freq_next;
    logic                 run_out_reg, run_out_next;
    logic                 fault_reg, fault_next;

    logic [COUNT_W-1:0]   cnt_reg, cnt_next;
    logic [TIME_BITS-1:0] ticks_reg, ticks_next;
    logic                 run_hold_reg, run_hold_next;
    logic [NUM_W-1:0]     num_reg, num_next;
    logic [DW-1:0]        div_reg, div_next;
    logic [DW-1:0]        rem_reg, rem_next;
    logic [ITER_W-1:0]    iter_reg, iter_next;

    logic [DW:0]          rem_shift;
    logic [DW:0]          rem_diff;
    logic                 ge;
    logic [NUM_W-1:0]     num_prod;
    logic [DW-1:0]        div_prod;

    assign head       = efc_op_t'(pop_data[OP_W-1:0]);
    assign head_ticks = pop_data[ENTRY_W-1 -: TIME_BITS];
    assign out_free   = !out_valid_reg || !out_stall;

    assign out_valid    = out_valid_reg;
    assign freq_hz      = freq_reg;
    assign running      = run_out_reg;
    assign divide_fault = fault_reg;

    assign num_prod  = cnt_reg * USEC_PER_SEC;
    assign div_prod  = ticks_reg * usec_per_tick;
    assign rem_shift = {rem_reg, num_reg[NUM_W-1]};
    assign rem_diff  = rem_shift - {1'b0, div_reg};
    assign ge        = rem_shift >= {1'b0, div_reg};

    always_comb
    begin
        state_next     = state_reg;
        pop            = 1'b0;
        out_valid_next = out_valid_reg && out_stall;
        freq_next      = freq_reg;
        run_out_next   = run_out_reg;
        fault_next     = fault_reg;
        cnt_next       = cnt_reg;
        ticks_next     = ticks_reg;
        run_hold_next  = run_hold_reg;
        num_next       = num_reg;
        div_next       = div_reg;
        rem_next       = rem_reg;
        iter_next      = iter_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    if (head.kind == KIND_DIV)
                    begin
                        pop           = 1'b1;
                        cnt_next      = head.count;
                        ticks_next    = head_ticks;
                        run_hold_next = head.running;
                        state_next    = ST_MUL;
                    end
                    else if (out_free)
                    begin
                        pop            = 1'b1;
                        out_valid_next = 1'b1;
                        run_out_next   = head.running;
                        fault_next     = 1'b0;
                        if (head.kind == KIND_ZERO)
                        begin
                            freq_next = '0;
                        end
                    end
                end
            end
            ST_MUL:
            begin
                num_next   = num_prod;
                div_next   = div_prod;
                rem_next   = '0;
                iter_next  = ITER_W'(NUM_W - 1);
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_reg == '0)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    // one restoring step: quotient bits shift in at the bottom
                    rem_next  = ge ? rem_diff[DW-1:0] : rem_shift[DW-1:0];
                    num_next  = {num_reg[NUM_W-2:0], ge};
                    iter_next = iter_reg - ITER_W'(1);
                    if (iter_reg == '0)
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    run_out_next   = run_hold_reg;
                    if (div_reg == '0)
                    begin
                        freq_next  = '0;
                        fault_next = 1'b1;
                    end
                    else
                    begin
                        fault_next = 1'b0;
                        freq_next  = (|num_reg[NUM_W-1:FREQ_W]) ? '1
                                                                : num_reg[FREQ_W-1:0];
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            freq_reg      <= '0;
            run_out_reg   <= 1'b0;
            fault_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            freq_reg      <= freq_next;
            run_out_reg   <= run_out_next;
            fault_reg     <= fault_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg      <= cnt_next;
        ticks_reg    <= ticks_next;
        run_hold_reg <= run_hold_next;
        num_reg      <= num_next;
        div_reg      <= div_next;
        rem_reg      <= rem_next;
        iter_reg     <= iter_next;
    end

    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall |=> out_valid_reg && $stable(freq_reg)
                                       && $stable(fault_reg) && $stable(run_out_reg))
        else $error("stalled result changed");

    a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && fault_reg |-> freq_reg == '0 && run_out_reg)
        else $error("fault with nonzero frequency");

    a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> state_reg == ST_IDLE)
        else $error("queue popped while busy");

    a_remainder_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV && div_reg != '0 |-> rem_reg < div_reg)
        else $error("remainder not below divisor");

endmodule

### hw/rtl/edge_frequency_counter.sv
// Path to the output transfer: edge, start, stop and an update while stopped go from
// the queue straight to the output registers; a running update goes through queue,
// multiply, 52-step divide and load, with no divide steps when its divisor is zero.
// Throughput: one non-update item per cycle while out_stall is low and the divider
// is idle; a 2-entry queue keeps accepting behind a running update in the divider.
// Reset (rst_n low, asynchronous): stopped, control state cleared, usec_per_tick 31.
module edge_frequency_counter #(
    parameter int TIME_BITS = efc_pkg::TIME_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [efc_pkg::USEC_W-1:0] cfg_wr_data,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [1:0]                 command,
    input  logic [efc_pkg::RTC_W-1:0]  rtc_time,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [efc_pkg::FREQ_W-1:0] freq_hz,
    output logic                       running,
    output logic                       divide_fault
);
    import efc_pkg::*;

    localparam int ENTRY_W = TIME_BITS + OP_W;

    logic [USEC_W-1:0]  usec_reg;
    logic               push, pop, q_full, q_valid;
    logic [ENTRY_W-1:0] push_data, pop_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            usec_reg <= USEC_RESET;
        end
        else if (cfg_wr_en)
        begin
            usec_reg <= cfg_wr_data;
        end
    end

    efc_front #(
        .TIME_BITS (TIME_BITS),
        .ENTRY_W   (ENTRY_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .command   (command),
        .rtc_time  (rtc_time),
        .push      (push),
        .push_data (push_data),
        .q_full    (q_full)
    );

    efc_queue #(
        .WIDTH (ENTRY_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .q_valid   (q_valid),
        .pop_data  (pop_data)
    );

    efc_back #(
        .TIME_BITS (TIME_BITS),
        .ENTRY_W   (ENTRY_W)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .pop_data      (pop_data),
        .pop           (pop),
        .usec_per_tick (usec_reg),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .freq_hz       (freq_hz),
        .running       (running),
        .divide_fault  (divide_fault)
    );

endmodule
